// ----- rtl/ocx_pkg.sv -----
package ocx_pkg;

   localparam int MAX_CITIES = 64;
   localparam int CITY_W     = 6;
   localparam int CITY_N     = 1 << CITY_W;
   localparam int IDX_W      = $clog2(MAX_CITIES);
   localparam int CNT_W      = $clog2(MAX_CITIES + 1);
   localparam int CMP_W      = (CNT_W > CITY_W) ? CNT_W : CITY_W;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SETUP,
      ST_SEG,
      ST_FILL,
      ST_EMIT
   } state_type;

endpackage

// ----- rtl/ocx_ram.sv -----
module ocx_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/order_crossover_permutation.sv -----
// Order crossover (OX1) of two parent tours of up to MAX_CITIES cities. Each
// beat on the request side loads one position of both parents, one beat per
// cycle while busy is low. The beat marked last_pos closes the load and starts
// the crossover; busy then stays high through a setup step, the copy of the
// segment from parent one, a scan of up to n positions of parent two (n being
// the number of loaded positions) and the output pass over the child, each
// pass paced by the single read port of the parent and child stores. On that
// pass the child is delivered as n response beats on consecutive cycles, each
// shown for one cycle with rsp_valid high. The receiver cannot stall: a beat
// not taken in its cycle is gone. A new load may start while the final beat
// is on the port.
module order_crossover_permutation (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [ocx_pkg::CITY_W-1:0] req_first_city,
   input  logic [ocx_pkg::CITY_W-1:0] req_second_city,
   input  logic [ocx_pkg::CITY_W-1:0] req_cut_a,
   input  logic [ocx_pkg::CITY_W-1:0] req_cut_b,
   input  logic                       req_last_pos,
   output logic                       rsp_valid,
   output logic [ocx_pkg::CITY_W-1:0] rsp_child_city,
   output logic                       rsp_child_last,
   output logic                       rsp_overflow
);

   localparam int IDX_W  = ocx_pkg::IDX_W;
   localparam int CNT_W  = ocx_pkg::CNT_W;
   localparam int CMP_W  = ocx_pkg::CMP_W;
   localparam int CITY_W = ocx_pkg::CITY_W;

   ocx_pkg::state_type state_ff, state_in;

   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        ovf_ff, ovf_in;
   logic [CNT_W-1:0]            n_ff, n_in;
   logic [CITY_W-1:0]           cut_a_ff, cut_a_in;
   logic [CITY_W-1:0]           cut_b_ff, cut_b_in;
   logic [IDX_W-1:0]            hi_ff, hi_in;
   logic [IDX_W-1:0]            rd_ff, rd_in;
   logic [CNT_W-1:0]            scan_ff, scan_in;
   logic                        iss_done_ff, iss_done_in;
   logic                        pend_ff, pend_in;
   logic [IDX_W-1:0]            pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [CNT_W-1:0]            free_ff, free_in;
   logic [ocx_pkg::CITY_N-1:0]  used_ff, used_in;
   logic [ocx_pkg::MAX_CITIES-1:0] valid_ff, valid_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [CITY_W-1:0]           rsp_city_ff, rsp_city_in;
   logic                        rsp_last_ff, rsp_last_in;
   logic                        rsp_ovf_ff, rsp_ovf_in;

   logic              accept;
   logic              load_wr;
   logic              child_wr;
   logic [IDX_W-1:0]  child_waddr;
   logic [CITY_W-1:0] child_wdata;
   logic [CITY_W-1:0] p1_rdata, p2_rdata, child_rdata;
   logic              issue;

   logic [CITY_W-1:0] cut_lo, cut_hi;
   logic [CMP_W-1:0]  nm1_w, lo_w, hi_w;
   logic [IDX_W-1:0]  lo_set, hi_set, hi_wrap;
   logic [CNT_W-1:0]  seg_len;

   assign busy    = (state_ff != ocx_pkg::ST_LOAD);
   assign accept  = start && !busy;
   assign load_wr = accept && (cnt_ff < CNT_W'(ocx_pkg::MAX_CITIES));

   ocx_ram #(.WIDTH(CITY_W), .DEPTH(ocx_pkg::MAX_CITIES)) u_first_store (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (cnt_ff[IDX_W-1:0]),
      .wr_data (req_first_city),
      .rd_addr (rd_ff),
      .rd_data (p1_rdata)
   );

   ocx_ram #(.WIDTH(CITY_W), .DEPTH(ocx_pkg::MAX_CITIES)) u_second_store (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (cnt_ff[IDX_W-1:0]),
      .wr_data (req_second_city),
      .rd_addr (rd_ff),
      .rd_data (p2_rdata)
   );

   ocx_ram #(.WIDTH(CITY_W), .DEPTH(ocx_pkg::MAX_CITIES)) u_child_store (
      .clock   (clock),
      .wr_en   (child_wr),
      .wr_addr (child_waddr),
      .wr_data (child_wdata),
      .rd_addr (rd_ff),
      .rd_data (child_rdata)
   );

   // order and clamp the cuts
   always_comb begin
      cut_lo = (cut_a_ff < cut_b_ff) ? cut_a_ff : cut_b_ff;
      cut_hi = (cut_a_ff < cut_b_ff) ? cut_b_ff : cut_a_ff;
      nm1_w  = CMP_W'(n_ff - CNT_W'(1));
      lo_w   = CMP_W'(cut_lo);
      hi_w   = CMP_W'(cut_hi);
      if (lo_w > nm1_w) begin
         lo_w = nm1_w;
      end
      if (hi_w > nm1_w) begin
         hi_w = nm1_w;
      end
      lo_set  = IDX_W'(lo_w);
      hi_set  = IDX_W'(hi_w);
      seg_len = CNT_W'(hi_set) - CNT_W'(lo_set) + CNT_W'(1);
      hi_wrap = ((CNT_W'(hi_set) + CNT_W'(1)) == n_ff) ? '0 : IDX_W'(hi_set + IDX_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ocx_pkg::ST_LOAD;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         iss_done_ff  <= 1'b0;
         used_ff      <= '0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         iss_done_ff  <= iss_done_in;
         used_ff      <= used_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff        <= n_in;
      cut_a_ff    <= cut_a_in;
      cut_b_ff    <= cut_b_in;
      hi_ff       <= hi_in;
      rd_ff       <= rd_in;
      scan_ff     <= scan_in;
      pend_idx_ff <= pend_idx_in;
      idx_ff      <= idx_in;
      free_ff     <= free_in;
      rsp_city_ff <= rsp_city_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      ovf_in       = ovf_ff;
      n_in         = n_ff;
      cut_a_in     = cut_a_ff;
      cut_b_in     = cut_b_ff;
      hi_in        = hi_ff;
      rd_in        = rd_ff;
      scan_in      = scan_ff;
      iss_done_in  = iss_done_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      idx_in       = idx_ff;
      free_in      = free_ff;
      used_in      = used_ff;
      valid_in     = valid_ff;
      rsp_valid_in = 1'b0;
      rsp_city_in  = rsp_city_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      child_wr     = 1'b0;
      child_waddr  = pend_idx_ff;
      child_wdata  = p1_rdata;
      issue        = 1'b0;

      unique case (state_ff)
         ocx_pkg::ST_LOAD: begin
            if (accept) begin
               if (load_wr) begin
                  cnt_in = cnt_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_pos) begin
                  n_in     = load_wr ? (cnt_ff + CNT_W'(1)) : cnt_ff;
                  cut_a_in = req_cut_a;
                  cut_b_in = req_cut_b;
                  state_in = ocx_pkg::ST_SETUP;
               end
            end
         end

         ocx_pkg::ST_SETUP: begin
            hi_in       = hi_set;
            rd_in       = lo_set;
            idx_in      = hi_wrap;
            free_in     = n_ff - seg_len;
            used_in     = '0;
            valid_in    = '0;
            iss_done_in = 1'b0;
            state_in    = ocx_pkg::ST_SEG;
         end

         // copy parent one's segment
         ocx_pkg::ST_SEG: begin
            issue = !iss_done_ff;
            if (issue) begin
               pend_in     = 1'b1;
               pend_idx_in = rd_ff;
               if (rd_ff == hi_ff) begin
                  iss_done_in = 1'b1;
               end else begin
                  rd_in = rd_ff + IDX_W'(1);
               end
            end
            if (pend_ff) begin
               child_wr              = 1'b1;
               child_waddr           = pend_idx_ff;
               child_wdata           = p1_rdata;
               valid_in[pend_idx_ff] = 1'b1;
               used_in[p1_rdata]     = 1'b1;
            end
            if (iss_done_ff && !pend_ff) begin
               rd_in    = ((CNT_W'(hi_ff) + CNT_W'(1)) == n_ff) ? '0
                                                                : IDX_W'(hi_ff + IDX_W'(1));
               scan_in  = '0;
               state_in = ocx_pkg::ST_FILL;
            end
         end

         // scan parent two from just after the second cut
         ocx_pkg::ST_FILL: begin
            issue = (scan_ff != n_ff) && (free_ff != '0);
            if (issue) begin
               pend_in = 1'b1;
               scan_in = scan_ff + CNT_W'(1);
               rd_in   = ((CNT_W'(rd_ff) + CNT_W'(1)) == n_ff) ? '0
                                                               : IDX_W'(rd_ff + IDX_W'(1));
            end
            if (pend_ff && (free_ff != '0) && !used_ff[p2_rdata]) begin
               used_in[p2_rdata] = 1'b1;
               child_wr          = 1'b1;
               child_waddr       = idx_ff;
               child_wdata       = p2_rdata;
               valid_in[idx_ff]  = 1'b1;
               idx_in            = ((CNT_W'(idx_ff) + CNT_W'(1)) == n_ff) ? '0
                                                                          : IDX_W'(idx_ff + IDX_W'(1));
               free_in           = free_ff - CNT_W'(1);
            end
            if (!issue && !pend_ff) begin
               rd_in    = '0;
               scan_in  = '0;
               state_in = ocx_pkg::ST_EMIT;
            end
         end

         ocx_pkg::ST_EMIT: begin
            issue = (scan_ff != n_ff);
            if (issue) begin
               pend_in     = 1'b1;
               pend_idx_in = rd_ff;
               scan_in     = scan_ff + CNT_W'(1);
               rd_in       = rd_ff + IDX_W'(1);
            end
            if (pend_ff) begin
               rsp_valid_in = 1'b1;
               rsp_city_in  = valid_ff[pend_idx_ff] ? child_rdata : '0;
               rsp_last_in  = ((CNT_W'(pend_idx_ff) + CNT_W'(1)) == n_ff);
               rsp_ovf_in   = ovf_ff;
            end
            if (!issue) begin
               cnt_in   = '0;
               ovf_in   = 1'b0;
               state_in = ocx_pkg::ST_LOAD;
            end
         end

         default: begin
            state_in = ocx_pkg::ST_LOAD;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_child_city = rsp_city_ff;
   assign rsp_child_last = rsp_last_ff;
   assign rsp_overflow   = rsp_ovf_ff;

   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ocx_pkg::ST_EMIT))
      else $error("response beat outside the output pass");

   a_last_ends_pass: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (state_ff == ocx_pkg::ST_LOAD))
      else $error("final child beat while crossover still running");

   a_free_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ocx_pkg::ST_FILL) |-> (free_ff <= n_ff))
      else $error("free position count exceeds tour length");

   a_cnt_bounded: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(ocx_pkg::MAX_CITIES))
      else $error("load count beyond capacity");

endmodule
